FILE: hw/rtl/pcg_pkg.sv
// ----------------------------------------------------------------------------
// pcg_pkg
// Types, register codes and reset values shared by the palette crossfade
// generator modules.
// ----------------------------------------------------------------------------
package pcg_pkg;

	localparam int NumColors = 6;
	localparam int ChanW     = 8;
	localparam int DurW      = 20;
	localparam int PhaseW    = 21;
	localparam int CountW    = 3;
	localparam int IdxW      = 3;
	localparam int DeltaW    = 16;
	localparam int CfgDataW  = 24;
	localparam int NumW      = ChanW + DurW;   // mix numerator, at most 255 * D

	typedef logic [23:0] rgb_t;

	typedef enum logic [2:0] {
		REG_COLOR0        = 3'd0,
		REG_COLOR1        = 3'd1,
		REG_COLOR2        = 3'd2,
		REG_COLOR3        = 3'd3,
		REG_COLOR4        = 3'd4,
		REG_COLOR5        = 3'd5,
		REG_DURATION      = 3'd6,
		REG_PALETTE_COUNT = 3'd7
	} reg_idx_t;

	localparam rgb_t [NumColors-1:0] ColorReset = {
		24'h340B40, 24'hFF4AD5, 24'h282DFA, 24'h1CFFEE, 24'hBAFF4A, 24'hEDEDED
	};
	localparam logic [DurW-1:0]   DurationReset = 20'd20000;
	localparam logic [CountW-1:0] CountReset    = 3'd6;
	localparam logic [CountW-1:0] CountMin      = 3'd2;
	localparam logic [CountW-1:0] CountMax      = 3'd6;

	typedef struct packed {
		rgb_t [NumColors-1:0] color;
		logic [DurW-1:0]      duration;
		logic [CountW-1:0]    count;
	} cfg_t;

	// operands for one channel of the mix unit
	typedef struct packed {
		logic [ChanW-1:0] a;
		logic [ChanW-1:0] b;
		logic [DurW-1:0]  p;
		logic [DurW-1:0]  d;
	} mix_req_t;

	// palette lookup; indices past the palette read black
	function automatic rgb_t color_at(cfg_t cfg, logic [IdxW-1:0] idx);
		rgb_t c;
		c = '0;
		case (idx)
			3'd0: c = cfg.color[0];
			3'd1: c = cfg.color[1];
			3'd2: c = cfg.color[2];
			3'd3: c = cfg.color[3];
			3'd4: c = cfg.color[4];
			3'd5: c = cfg.color[5];
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

FILE: hw/rtl/pcg_cfg_regs.sv
// ----------------------------------------------------------------------------
// pcg_cfg_regs
// Configuration register file: six palette entries, fade duration and
// palette count, written over a valid/ready channel.
// ----------------------------------------------------------------------------
module pcg_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pcg_pkg::IdxW-1:0]       cfg_index,
	input  logic [pcg_pkg::CfgDataW-1:0]   cfg_data,
	output pcg_pkg::cfg_t                  cfg
);
	import pcg_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color    <= ColorReset;
			cfg_q.duration <= DurationReset;
			cfg_q.count    <= CountReset;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_COLOR0:        cfg_q.color[0] <= cfg_data;
				REG_COLOR1:        cfg_q.color[1] <= cfg_data;
				REG_COLOR2:        cfg_q.color[2] <= cfg_data;
				REG_COLOR3:        cfg_q.color[3] <= cfg_data;
				REG_COLOR4:        cfg_q.color[4] <= cfg_data;
				REG_COLOR5:        cfg_q.color[5] <= cfg_data;
				REG_DURATION:      cfg_q.duration <= cfg_data[DurW-1:0];
				REG_PALETTE_COUNT: cfg_q.count <= cfg_data[CountW-1:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: hw/rtl/pcg_mix_unit.sv
// ----------------------------------------------------------------------------
// pcg_mix_unit
// Shared mix unit: forms a*(D-p), then adds b*p, on one 8x20 multiplier and
// divides the sum by D with an eight-step restoring divider.
// ----------------------------------------------------------------------------
module pcg_mix_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  pcg_pkg::mix_req_t            req,
	output logic                         done,
	output logic [pcg_pkg::ChanW-1:0]    quot
);
	import pcg_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL_A,
		S_MUL_B,
		S_DIV
	} mix_state_t;

	mix_state_t        state_q;
	logic [NumW-1:0]   acc_q;
	logic [NumW-1:0]   div_q;
	logic [2:0]        bit_q;
	logic [ChanW-1:0]  quot_q;
	logic              done_q;

	logic [ChanW-1:0]  mul_x;
	logic [DurW-1:0]   mul_y;
	logic [NumW-1:0]   prod;
	logic              ge;

	// p never exceeds D, so D - p cannot wrap
	assign mul_x = (state_q == S_MUL_A) ? req.a : req.b;
	assign mul_y = (state_q == S_MUL_A) ? (req.d - req.p) : req.p;
	assign prod  = NumW'(mul_x) * NumW'(mul_y);
	assign ge    = (acc_q >= div_q);

	assign done = done_q;
	assign quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			acc_q   <= '0;
			div_q   <= '0;
			bit_q   <= '0;
			quot_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start)
						state_q <= S_MUL_A;
				end
				S_MUL_A: begin
					acc_q   <= prod;
					state_q <= S_MUL_B;
				end
				S_MUL_B: begin
					// quotient fits in 8 bits: numerator is at most 255 * D
					acc_q   <= acc_q + prod;
					div_q   <= {1'b0, req.d, 7'd0};
					bit_q   <= 3'd7;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (ge)
						acc_q <= acc_q - div_q;
					quot_q <= {quot_q[ChanW-2:0], ge};
					div_q  <= div_q >> 1;
					bit_q  <= bit_q - 3'd1;
					if (bit_q == 3'd0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/palette_crossfade_generator_unit.sv
// ----------------------------------------------------------------------------
// palette_crossfade_generator_unit
// Each update transaction carries the milliseconds since the previous one and
// returns one colour: a linear fade between two palette entries, taken from
// the phase as it stood before the update, plus a flag when the update steps
// to the next palette pair. The three channels go one after another through a
// single shared 8x20 multiplier and 8-step restoring divider, each channel
// passing through a start, the multiply, eight divide steps and a hand-back.
// The result sits in an output register and the next update can be taken in
// the cycle after it is loaded, so an update is not taken until the previous
// one has been handed to that register; a stalled result only holds the
// block once the following update has finished its channels. Configuration
// writes are never stalled (cfg_ready is tied high) and should only be issued
// while no update is in flight.
// ----------------------------------------------------------------------------
module palette_crossfade_generator_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pcg_pkg::IdxW-1:0]       cfg_index,
	input  logic [pcg_pkg::CfgDataW-1:0]   cfg_data,
	// update input
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [pcg_pkg::DeltaW-1:0]     elapsed_ms,
	// colour output
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [pcg_pkg::ChanW-1:0]      red,
	output logic [pcg_pkg::ChanW-1:0]      green,
	output logic [pcg_pkg::ChanW-1:0]      blue,
	output logic                           advanced
);
	import pcg_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_WAIT,
		S_DONE
	} seq_state_t;

	cfg_t              cfg;
	mix_req_t          req;
	logic              mix_start;
	logic              mix_done;
	logic [ChanW-1:0]  mix_quot;

	seq_state_t        state_q;
	logic [1:0]        chan_q;
	logic [PhaseW-1:0] phase_q;
	logic [IdxW-1:0]   from_q;
	logic [IdxW-1:0]   to_q;
	rgb_t              fc_q;
	rgb_t              tc_q;
	logic [DurW-1:0]   p_q;
	logic [DurW-1:0]   d_q;
	logic              adv_q;
	logic [ChanW-1:0]  red_q, green_q, blue_q;
	logic              out_valid_q;
	logic [ChanW-1:0]  out_red_q, out_green_q, out_blue_q;
	logic              out_adv_q;

	logic [DurW-1:0]   d_eff;
	logic [DurW-1:0]   p_eff;
	logic              step;
	logic [PhaseW-1:0] phase_base;
	logic [PhaseW:0]   phase_sum;
	logic [PhaseW-1:0] phase_next;
	logic [CountW-1:0] cnt_eff;
	logic [IdxW:0]     to_inc;
	logic [IdxW-1:0]   to_next;
	logic              in_accept;
	logic              out_free;
	logic              out_load;

	pcg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pcg_mix_unit u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mix_start),
		.req    (req),
		.done   (mix_done),
		.quot   (mix_quot)
	);

	// effective settings
	assign d_eff   = (cfg.duration == '0) ? DurW'(1) : cfg.duration;
	assign cnt_eff = (cfg.count < CountMin) ? CountMin :
	                 (cfg.count > CountMax) ? CountMax : cfg.count;

	// phase and index update, taken from the old state at acceptance
	assign step       = (phase_q >= {1'b0, d_eff});
	assign p_eff      = step ? d_eff : phase_q[DurW-1:0];
	assign phase_base = step ? (phase_q - {1'b0, d_eff}) : phase_q;
	assign phase_sum  = {1'b0, phase_base} + (PhaseW+1)'(elapsed_ms);
	assign phase_next = phase_sum[PhaseW] ? {PhaseW{1'b1}} : phase_sum[PhaseW-1:0];
	assign to_inc     = {1'b0, to_q} + (IdxW+1)'(1);
	assign to_next    = (to_inc >= {1'b0, cnt_eff}) ? '0 : to_inc[IdxW-1:0];

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == S_DONE) && out_free;

	// channel select: 0 red, 1 green, 2 blue
	always_comb begin
		req.p = p_q;
		req.d = d_q;
		case (chan_q)
			2'd0: begin
				req.a = fc_q[23:16];
				req.b = tc_q[23:16];
			end
			2'd1: begin
				req.a = fc_q[15:8];
				req.b = tc_q[15:8];
			end
			default: begin
				req.a = fc_q[7:0];
				req.b = tc_q[7:0];
			end
		endcase
	end

	assign mix_start = (state_q == S_START);

	assign out_valid = out_valid_q;
	assign red       = out_red_q;
	assign green     = out_green_q;
	assign blue      = out_blue_q;
	assign advanced  = out_adv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			chan_q      <= '0;
			phase_q     <= '0;
			from_q      <= IdxW'(0);
			to_q        <= IdxW'(1);
			fc_q        <= '0;
			tc_q        <= '0;
			p_q         <= '0;
			d_q         <= '0;
			adv_q       <= 1'b0;
			red_q       <= '0;
			green_q     <= '0;
			blue_q      <= '0;
			out_valid_q <= 1'b0;
			out_red_q   <= '0;
			out_green_q <= '0;
			out_blue_q  <= '0;
			out_adv_q   <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						fc_q    <= color_at(cfg, from_q);
						tc_q    <= color_at(cfg, to_q);
						p_q     <= p_eff;
						d_q     <= d_eff;
						adv_q   <= step;
						phase_q <= phase_next;
						if (step) begin
							from_q <= to_q;
							to_q   <= to_next;
						end
						chan_q  <= 2'd0;
						state_q <= S_START;
					end
				end
				S_START: state_q <= S_WAIT;
				S_WAIT: begin
					if (mix_done) begin
						case (chan_q)
							2'd0:    red_q   <= mix_quot;
							2'd1:    green_q <= mix_quot;
							default: blue_q  <= mix_quot;
						endcase
						if (chan_q == 2'd2) begin
							state_q <= S_DONE;
						end else begin
							chan_q  <= chan_q + 2'd1;
							state_q <= S_START;
						end
					end
				end
				S_DONE: begin
					// wait for the output register to free up
					if (out_free) begin
						out_red_q   <= red_q;
						out_green_q <= green_q;
						out_blue_q  <= blue_q;
						out_adv_q   <= adv_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: tb/palette_crossfade_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_crossfade_checker
// Watches the configuration, update and colour channels of the palette
// crossfade generator. Keeps a shadow of the registers and the fade state,
// predicts the colour for every accepted update and compares each accepted
// colour transaction, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module palette_crossfade_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [pcg_pkg::IdxW-1:0]     cfg_index,
	input  logic [pcg_pkg::CfgDataW-1:0] cfg_data,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [pcg_pkg::DeltaW-1:0]   elapsed_ms,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [pcg_pkg::ChanW-1:0]    red,
	input  logic [pcg_pkg::ChanW-1:0]    green,
	input  logic [pcg_pkg::ChanW-1:0]    blue,
	input  logic                         advanced,
	output int                           fail_count,
	output int                           outstanding
);
	import pcg_pkg::*;

	localparam logic [PhaseW-1:0] PhaseMax = '1;

	typedef struct packed {
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] blue;
		logic             advanced;
	} colour_t;

	// shadow registers; entries 6 and 7 read as black
	rgb_t              palette [8];
	logic [DurW-1:0]   duration;
	logic [CountW-1:0] count;

	// fade state
	logic [PhaseW-1:0] phase;
	logic [IdxW-1:0]   from_idx;
	logic [IdxW-1:0]   to_idx;

	colour_t colour_q [$];
	int      in_count;
	int      out_count;
	int      fails;

	assign outstanding = in_count - out_count;
	assign fail_count  = fails;

	function automatic logic [ChanW-1:0] blend(input logic [ChanW-1:0] a,
			input logic [ChanW-1:0] b, input logic [DurW-1:0] p,
			input logic [DurW-1:0] d);
		logic [31:0] av, bv, pv, dv, num;
		av  = {24'd0, a};
		bv  = {24'd0, b};
		pv  = {12'd0, p};
		dv  = {12'd0, d};
		num = av * (dv - pv) + bv * pv;
		num = num / dv;
		return num[ChanW-1:0];
	endfunction

	// colour from the phase before the update, then step and accumulate
	function automatic colour_t predict_colour(input logic [DeltaW-1:0] ms);
		colour_t           c;
		logic [DurW-1:0]   d;
		logic [CountW-1:0] n;
		logic [PhaseW-1:0] p;
		logic [IdxW:0]     nxt;
		logic [PhaseW:0]   sum;
		rgb_t              fc, tc;
		d  = (duration == '0) ? DurW'(1) : duration;
		n  = (count < CountMin) ? CountMin : ((count > CountMax) ? CountMax : count);
		p  = (phase > {1'b0, d}) ? {1'b0, d} : phase;
		fc = palette[from_idx];
		tc = palette[to_idx];
		c.red      = blend(fc[23:16], tc[23:16], p[DurW-1:0], d);
		c.green    = blend(fc[15:8], tc[15:8], p[DurW-1:0], d);
		c.blue     = blend(fc[7:0], tc[7:0], p[DurW-1:0], d);
		c.advanced = 1'b0;
		if (phase >= {1'b0, d}) begin
			c.advanced = 1'b1;
			nxt      = {1'b0, to_idx} + 1'b1;
			from_idx = to_idx;
			to_idx   = (nxt >= {1'b0, n}) ? '0 : nxt[IdxW-1:0];
			phase    = phase - {1'b0, d};
		end
		sum   = {1'b0, phase} + {6'd0, ms};
		phase = (sum > {1'b0, PhaseMax}) ? PhaseMax : sum[PhaseW-1:0];
		return c;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns  %s: got %0d, expected %0d", $time, what, got, want);
		fails++;
	endtask

	initial fails = 0;

	always @(posedge clk or negedge arst_n) begin : monitor
		colour_t want;
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				palette[i] = (i < NumColors) ? ColorReset[i] : '0;
			duration  = DurationReset;
			count     = CountReset;
			phase     = '0;
			from_idx  = '0;
			to_idx    = IdxW'(1);
			colour_q.delete();
			in_count  <= 0;
			out_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_COLOR0, REG_COLOR1, REG_COLOR2,
					REG_COLOR3, REG_COLOR4, REG_COLOR5:
						palette[cfg_index] = cfg_data;
					REG_DURATION:      duration = cfg_data[DurW-1:0];
					REG_PALETTE_COUNT: count    = cfg_data[CountW-1:0];
					default: ;
				endcase
			end
			// retire before predicting so a same-edge transaction lines up
			if (out_valid && !out_stall) begin
				if (colour_q.size() == 0) begin
					report_mismatch("colour transaction with none pending",
							{red, green, blue}, -1);
				end else begin
					want = colour_q.pop_front();
					if (red !== want.red)
						report_mismatch("red", red, want.red);
					if (green !== want.green)
						report_mismatch("green", green, want.green);
					if (blue !== want.blue)
						report_mismatch("blue", blue, want.blue);
					if (advanced !== want.advanced)
						report_mismatch("advanced", advanced, want.advanced);
					out_count <= out_count + 1;
				end
			end
			if (in_valid && !in_stall) begin
				colour_q.push_back(predict_colour(elapsed_ms));
				in_count <= in_count + 1;
			end
		end
	end

endmodule

FILE: tb/tb_palette_crossfade_generator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_palette_crossfade_generator_unit
// Drives update and configuration transactions into the palette crossfade
// generator: a short directed run over the register and delta extremes, then
// randomised register settings with deltas shaped around the fade length,
// under four sender/receiver idling profiles. Checking lives in the checker.
// ----------------------------------------------------------------------------
module tb_palette_crossfade_generator_unit;
	import pcg_pkg::*;

	typedef enum int {PAL_RESET, PAL_BW, PAL_RANDOM} pal_mode_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                cfg_valid  = 1'b0;
	logic                cfg_ready;
	logic [IdxW-1:0]     cfg_index  = '0;
	logic [CfgDataW-1:0] cfg_data   = '0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic [DeltaW-1:0]   elapsed_ms = '0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic [ChanW-1:0]    red, green, blue;
	logic                advanced;

	int fail_count;
	int outstanding;

	int              send_idle  = 0;   // percent of cycles the sender idles
	int              recv_stall = 0;   // percent of cycles the receiver stalls
	logic [DurW-1:0] dur_cur    = DurationReset;
	logic [DeltaW-1:0] ms_q [$];

	palette_crossfade_generator_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.elapsed_ms (elapsed_ms),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.advanced   (advanced)
	);

	palette_crossfade_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.elapsed_ms  (elapsed_ms),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.advanced    (advanced),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall);

	task automatic write_reg(input reg_idx_t idx, input logic [CfgDataW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// only called with nothing in flight
	task automatic program_regs(input logic [DurW-1:0] dur, input logic [CountW-1:0] cnt,
			input pal_mode_t mode);
		rgb_t c;
		for (int i = 0; i < NumColors; i++) begin
			case (mode)
				PAL_RESET: c = ColorReset[i];
				PAL_BW:    c = (i % 2 == 0) ? 24'h000000 : 24'hFFFFFF;
				default: begin
					case ($urandom_range(5))
						0:       c = 24'h000000;
						1:       c = 24'hFFFFFF;
						default: c = rgb_t'($urandom);
					endcase
				end
			endcase
			write_reg(reg_idx_t'(i), c);
		end
		write_reg(REG_DURATION, {4'd0, dur});
		write_reg(REG_PALETTE_COUNT, {21'd0, cnt});
		cfg_valid <= 1'b0;
		dur_cur = dur;
	endtask

	task automatic send_update(input logic [DeltaW-1:0] ms);
		in_valid   <= 1'b1;
		elapsed_ms <= ms;
		do @(posedge clk); while (in_stall);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic send_queued();
		foreach (ms_q[i])
			send_update(ms_q[i]);
		wait_idle();
	endtask

	// deltas shaped against the fade length so fades are crossed at all depths
	function automatic logic [DeltaW-1:0] pick_elapsed();
		int unsigned   span;
		logic [DeltaW-1:0] ms;
		span = (dur_cur == '0) ? 1 : dur_cur;
		if (span > 65535) span = 65535;
		case ($urandom_range(7))
			0:       ms = '0;
			1:       ms = '1;
			2, 3:    ms = DeltaW'($urandom_range(span));
			4, 5:    ms = DeltaW'($urandom_range(span / 4 + 1));
			default: ms = DeltaW'($urandom);
		endcase
		return ms;
	endfunction

	function automatic logic [DurW-1:0] pick_duration();
		logic [DurW-1:0] d;
		case ($urandom_range(7))
			0:       d = '0;
			1:       d = DurW'(1);
			2:       d = '1;
			3:       d = DurW'($urandom_range(100, 2));
			4, 5:    d = DurW'($urandom_range(65535, 100));
			default: d = DurW'($urandom);
		endcase
		return d;
	endfunction

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values
		ms_q = '{16'd0, 16'd20000, 16'd19999, 16'd1, 16'hFFFF, 16'd0};
		send_queued();
		// zero duration acts as one, count below range
		program_regs('0, 3'd0, PAL_BW);
		ms_q = '{16'd0, 16'hFFFF, 16'd1, 16'd0};
		send_queued();
		program_regs(DurW'(1), 3'd1, PAL_RANDOM);
		ms_q = '{16'd2, 16'd0, 16'd3};
		send_queued();
		// longest fade, count above range
		program_regs('1, 3'd7, PAL_RANDOM);
		ms_q = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0};
		send_queued();
		program_regs(DurW'(1000000), 3'd6, PAL_RESET);
		ms_q = '{16'hFFFF, 16'd32768, 16'd0, 16'd12345};
		send_queued();
		// half-way points round down
		program_regs(DurW'(2), 3'd3, PAL_BW);
		ms_q = '{16'd1, 16'd1, 16'd1};
		send_queued();

		for (int g = 0; g < 30; g++) begin
			program_regs(pick_duration(), CountW'($urandom_range(7)),
					($urandom_range(9) == 0) ? PAL_RESET : PAL_RANDOM);
			case (g % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 84; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 84; end
				default: begin send_idle = 11; recv_stall = 11; end
			endcase
			for (int i = 0; i < 30; i++)
				send_update(pick_elapsed());
			wait_idle();
		end

		recv_stall = 0;
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("palette_crossfade_generator_unit: match");
		else
			$display("palette_crossfade_generator_unit: mismatch");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("palette_crossfade_generator_unit: mismatch");
		$finish;
	end

endmodule
